// ===== src/dhtp_pkg.sv =====
// Package for the double hash table probe core.
// Holds status codes, sequencer state type and the golden-ratio constant.
package dhtp_pkg;
    localparam logic [31:0] GOLDEN_Q32 = 32'h9E3779B9;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_FULL      = 2'd1,
        ST_FOUND     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_STEP,
        S_READ,
        S_CHECK,
        S_DONE,
        S_CLEAR
    } t_state;
endpackage

// ===== src/dhtp_if.sv =====
// Valid/ready channel interfaces of the double hash table probe core.
// Depends on nothing.
interface dhtp_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic signed [31:0] key_value;
    modport source (output valid, req_type, key_value, input ready);
    modport sink   (input valid, req_type, key_value, output ready);
endinterface

interface dhtp_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [9:0]  slot_index;
    logic [10:0] probe_count;
    modport source (output valid, status, slot_index, probe_count, input ready);
    modport sink   (input valid, status, slot_index, probe_count, output ready);
endinterface

interface dhtp_cfg_if;
    logic        valid;
    logic        ready;
    logic [10:0] table_size;
    modport source (output valid, table_size, input ready);
    modport sink   (input valid, table_size, output ready);
endinterface

// ===== src/dhtp_ram.sv =====
// Generic single-port RAM with registered read.
// Depends on nothing.
module dhtp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== src/dhtp_divider.sv =====
// Iterative restoring remainder unit: one quotient bit per cycle.
// Computes floored (key mod n) for signed keys; depends on nothing.
module dhtp_divider #(
    parameter int NW = 17
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [31:0]   i_key,
    input  logic [NW-1:0]        i_n,
    output logic                 o_done,
    output logic [NW-1:0]        o_rem
);
    logic [31:0]   r_mag, n_mag;
    logic [NW:0]   r_rem, n_rem;
    logic [5:0]    r_cnt, n_cnt;
    logic          r_busy, n_busy, r_neg, n_neg, r_fix, n_fix;
    logic [NW:0]   w_sh;

    always_comb begin
        n_mag  = r_mag;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_neg  = r_neg;
        n_fix  = 1'b0;
        w_sh   = {r_rem[NW-1:0], r_mag[31]};
        if (i_start) begin
            n_mag  = i_key[31] ? 32'(-i_key) : i_key;
            n_neg  = i_key[31];
            n_rem  = '0;
            n_cnt  = 6'd32;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_mag = {r_mag[30:0], 1'b0};
            n_rem = (w_sh >= {1'b0, i_n}) ? w_sh - {1'b0, i_n} : w_sh;
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_fix  = 1'b1;
            end
        end else if (r_fix && r_neg && r_rem != '0) begin
            n_rem = {1'b0, i_n} - r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_fix  <= n_fix;
            r_cnt  <= n_cnt;
        end
        r_mag <= n_mag;
        r_rem <= n_rem;
        r_neg <= n_neg;
    end

    assign o_done = r_fix;
    assign o_rem  = (r_neg && r_rem != '0) ? NW'({1'b0, i_n} - r_rem) : r_rem[NW-1:0];

    a_busy_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_fix)) else $error("divider busy while done");
    a_rem_lt_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_rem < i_n) else $error("remainder not below n");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held");
endmodule

// ===== src/double_hash_table_probe_core.sv =====
// Double-hashing open-addressing hash table of signed 32-bit keys.
// After a request is accepted, the key is latched, its Q0.32 product is formed for the step,
// and a bit-serial remainder unit computes the first hash. Each slot probed is then read
// through the key RAM's registered read port and checked, and the result is held until it
// is taken. One request is processed at a time. Writing table_size, and reset, start a
// clearing pass over the occupied marks of all TABLE_DEPTH slots during which no request
// is accepted.
module double_hash_table_probe_core #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dhtp_cfg_if.sink    cfg,
    dhtp_req_if.sink    req,
    dhtp_rsp_if.source  rsp
);
    import dhtp_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = AW + 1;

    t_state r_state, n_state;
    logic [10:0]   r_size;
    logic [NW-1:0] w_n;
    logic          r_search;
    logic [31:0]   r_key;
    logic [31:0]   r_prod;
    logic [NW-1:0] r_step, r_pos, r_cnt;
    logic [AW-1:0] r_clr;
    logic [1:0]    r_status;
    logic [9:0]    r_slot;
    logic [10:0]   r_count;
    logic          r_occ_rd;
    logic [31:0]   w_rkey;
    logic          w_ddone;
    logic [NW-1:0] w_rem;
    logic          w_we, w_owe, w_oval;
    logic [AW-1:0] w_addr;
    logic          w_hit_empty, w_hit_key, w_last;
    logic [NW:0]   w_next;

    always_comb begin
        if (r_size == 11'd0) w_n = NW'(1);
        else if ({21'd0, r_size} > 32'(TABLE_DEPTH)) w_n = NW'(TABLE_DEPTH);
        else w_n = NW'(r_size);
    end

    dhtp_divider #(.NW(NW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(req.valid && req.ready), .i_key(req.key_value),
        .i_n(w_n), .o_done(w_ddone), .o_rem(w_rem)
    );

    assign w_addr = (r_state == S_CLEAR) ? r_clr : r_pos[AW-1:0];
    assign w_hit_empty = !r_occ_rd;
    assign w_hit_key   = r_search && w_rkey == r_key;
    assign w_last      = r_cnt == w_n;
    assign w_next      = {1'b0, r_pos} + {1'b0, r_step};
    assign w_we  = r_state == S_CHECK && w_hit_empty && !r_search;
    assign w_owe = w_we || r_state == S_CLEAR;
    assign w_oval = r_state != S_CLEAR;

    dhtp_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_keys (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr), .i_wdata(r_key), .o_rdata(w_rkey)
    );

    dhtp_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_occ (
        .i_clk(i_clk), .i_we(w_owe), .i_addr(w_addr), .i_wdata(w_oval), .o_rdata(r_occ_rd)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (cfg.valid) n_state = S_CLEAR;
                     else if (req.valid) n_state = S_HASH;
            S_HASH:  n_state = S_STEP;
            S_STEP:  if (w_ddone) n_state = S_READ;
            S_READ:  n_state = S_CHECK;
            S_CHECK: if (w_hit_empty || w_hit_key || w_last) n_state = S_DONE;
                     else n_state = S_READ;
            S_DONE:  if (rsp.ready) n_state = S_IDLE;
            S_CLEAR: if (r_clr == AW'(TABLE_DEPTH - 1)) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        req.ready       = r_state == S_IDLE && !cfg.valid;
        cfg.ready       = r_state == S_IDLE;
        rsp.valid       = r_state == S_DONE;
        rsp.status      = r_status;
        rsp.slot_index  = r_slot;
        rsp.probe_count = r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_size  <= 11'd1024;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (cfg.valid && cfg.ready) r_size <= cfg.table_size;
            if (r_state == S_CLEAR) r_clr <= r_clr + AW'(1);
            else r_clr <= '0;
        end
        if (req.valid && req.ready) begin
            r_key    <= req.key_value;
            r_search <= req.req_type;
        end
        if (r_state == S_HASH) r_prod <= r_key * GOLDEN_Q32;
        if (r_state == S_STEP) begin
            r_step <= NW'(({32'd0, r_prod} * {{(64 - NW){1'b0}}, w_n}) >> 32);
            r_cnt  <= '0;
            if (w_ddone) r_pos <= w_rem;
        end
        if (r_state == S_READ) r_cnt <= r_cnt + NW'(1);
        if (r_state == S_CHECK) begin
            r_slot  <= 10'(r_pos);
            r_count <= 11'(r_cnt);
            if (w_hit_empty) r_status <= r_search ? ST_NOT_FOUND : ST_INSERTED;
            else if (w_hit_key) r_status <= ST_FOUND;
            else r_status <= r_search ? ST_NOT_FOUND : ST_FULL;
            if (!(w_hit_empty || w_hit_key || w_last))
                r_pos <= (w_next >= {1'b0, w_n}) ? NW'(w_next - {1'b0, w_n}) : NW'(w_next);
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CHECK |-> r_pos < w_n) else $error("probe outside table");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CHECK |-> r_cnt >= NW'(1) && r_cnt <= w_n) else $error("bad count");
    a_no_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !req.ready) else $error("ready while busy");
    a_we_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> !r_occ_rd) else $error("overwrite occupied slot");
endmodule

// ===== verif/tb_top.sv =====
// Testbench for double_hash_table_probe_core: insert/search requests checked against
// an in-bench model of the double-hashing table. Depends on dhtp_pkg, dhtp_if and the core.
`timescale 1ns / 100ps

module tb_top;
    import dhtp_pkg::*;

    typedef struct packed {
        logic        req_type;
        logic [31:0] key_value;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  slot_index;
        logic [10:0] probe_count;
    } t_rsp;

    localparam int DEPTH = 1024;
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;
    localparam longint CYCLE_LIMIT = 20000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    dhtp_cfg_if cfg ();
    dhtp_req_if req ();
    dhtp_rsp_if rsp ();

    double_hash_table_probe_core #(.TABLE_DEPTH(DEPTH)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .cfg    (cfg.sink),
        .req    (req.sink),
        .rsp    (rsp.source)
    );

    // model state
    int unsigned model_size;
    bit          model_occ [DEPTH];
    logic [31:0] model_key [DEPTH];
    t_req        pending_reqs [$];
    t_rsp        expected_rsps [$];
    logic [31:0] inserted_keys [$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_off_cycles;
    int          fail_count;
    longint      cycle_count;

    function automatic t_rsp probe_table(t_req r);
        t_rsp        res;
        longint      skey;
        longint      rem;
        int unsigned pos;
        int unsigned stride;
        logic [63:0] prod;
        logic [63:0] frac;
        bit          is_search;
        is_search = (r.req_type == REQ_SEARCH);
        skey = longint'($signed(r.key_value));
        rem = skey % longint'(model_size);
        if (rem < 0) rem += model_size;
        pos = 32'(rem);
        prod = 64'(r.key_value) * 64'(GOLDEN_Q32);
        frac = {32'd0, prod[31:0]};
        stride = 32'((frac * 64'(model_size)) >> 32);
        res.status = is_search ? ST_NOT_FOUND : ST_FULL;
        res.slot_index = pos[9:0];
        res.probe_count = model_size[10:0];
        for (int i = 0; i < model_size; i++) begin
            res.slot_index = pos[9:0];
            if (!model_occ[pos]) begin
                if (!is_search) begin
                    model_occ[pos] = 1'b1;
                    model_key[pos] = r.key_value;
                    res.status = ST_INSERTED;
                end else begin
                    res.status = ST_NOT_FOUND;
                end
                res.probe_count = 11'(i + 1);
                return res;
            end
            if (is_search && model_key[pos] == r.key_value) begin
                res.status = ST_FOUND;
                res.probe_count = 11'(i + 1);
                return res;
            end
            pos += stride;
            if (pos >= model_size) pos -= model_size;
        end
        return res;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req.valid <= 1'b0;
            req.req_type <= REQ_INSERT;
            req.key_value <= '0;
        end else if (!req.valid || req.ready) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                t_req r;
                r = pending_reqs.pop_front();
                expected_rsps.push_back(probe_table(r));
                req.valid <= 1'b1;
                req.req_type <= r.req_type;
                req.key_value <= r.key_value;
            end else begin
                req.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_off_cycles > 0) hold_off_cycles <= hold_off_cycles - 1;
    end

    // monitor and receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp.ready <= 1'b0;
        end else begin
            if (rsp.valid && rsp.ready) begin
                if (expected_rsps.size() == 0) begin
                    $error("unexpected beat status=%0d", rsp.status);
                    fail_count++;
                end else begin
                    t_rsp e;
                    e = expected_rsps.pop_front();
                    if (rsp.status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, rsp.status);
                        fail_count++;
                    end
                    if (rsp.slot_index !== e.slot_index) begin
                        $error("slot_index exp %0d got %0d", e.slot_index, rsp.slot_index);
                        fail_count++;
                    end
                    if (rsp.probe_count !== e.probe_count) begin
                        $error("probe_count exp %0d got %0d", e.probe_count,
                               rsp.probe_count);
                        fail_count++;
                    end
                end
            end
            if (hold_off_cycles > 0) begin
                rsp.ready <= 1'b0;
            end else begin
                rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic add_req(logic kind, logic [31:0] k);
        t_req r;
        r.req_type = kind;
        r.key_value = k;
        pending_reqs.push_back(r);
        if (kind == REQ_INSERT) inserted_keys.push_back(k);
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req.valid)
            @(posedge i_clk);
        repeat (2200) @(posedge i_clk);
    endtask

    task automatic write_size(logic [10:0] sz);
        cfg.valid <= 1'b1;
        cfg.table_size <= sz;
        @(negedge i_clk);
        while (!cfg.ready) @(negedge i_clk);
        @(posedge i_clk);
        cfg.valid <= 1'b0;
        model_size = (sz == 0) ? 1 : (sz > DEPTH ? DEPTH : sz);
        for (int i = 0; i < DEPTH; i++) model_occ[i] = 1'b0;
        inserted_keys.delete();
    endtask

    function automatic logic [31:0] rand_key();
        case ($urandom_range(3))
            0: return $urandom_range(64);
            1: return -$urandom_range(64);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(int count, int full_pct);
        logic [31:0] k;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < full_pct || inserted_keys.size() == 0)
                add_req(REQ_INSERT, rand_key());
            else if ($urandom_range(1) == 1)
                add_req(REQ_SEARCH,
                        inserted_keys[$urandom_range(inserted_keys.size() - 1)]);
            else begin
                k = rand_key();
                add_req(REQ_SEARCH, k);
            end
        end
    endtask

    initial begin
        int sizes [6] = '{1, 2, 7, 0, 1024, 2047};
        cfg.valid = 1'b0;
        cfg.table_size = '0;
        req.valid = 1'b0;
        req.req_type = REQ_INSERT;
        req.key_value = '0;
        rsp.ready = 1'b0;
        model_size = DEPTH;
        for (int i = 0; i < DEPTH; i++) begin
            model_occ[i] = 1'b0;
            model_key[i] = '0;
        end
        send_idle_pct = 32;
        recv_idle_pct = 63;
        hold_off_cycles = 0;
        fail_count = 0;
        cycle_count = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (DEPTH + 20) @(posedge i_clk);

        // directed at reset size
        add_req(REQ_SEARCH, 32'h8000_0000);
        add_req(REQ_INSERT, 32'h8000_0000);
        add_req(REQ_INSERT, 32'h7FFF_FFFF);
        add_req(REQ_INSERT, 32'hFFFF_FFFF);
        add_req(REQ_INSERT, 32'd0);
        add_req(REQ_INSERT, 32'd0);
        add_req(REQ_INSERT, 32'd1024);
        add_req(REQ_SEARCH, 32'd0);
        add_req(REQ_SEARCH, 32'h7FFF_FFFF);
        add_req(REQ_SEARCH, 32'd2048);
        add_req(REQ_SEARCH, 32'hFFFF_FFFF);
        drain();

        // tiny tables: full and exhausted searches, zero step
        write_size(11'd1);
        add_req(REQ_INSERT, 32'd5);
        add_req(REQ_INSERT, 32'd6);
        add_req(REQ_SEARCH, 32'd6);
        add_req(REQ_SEARCH, 32'd5);
        drain();
        write_size(11'd2);
        for (int i = 0; i < 4; i++) add_req(REQ_INSERT, -i);
        add_req(REQ_SEARCH, 32'd9);
        add_req(REQ_SEARCH, -32'sd1);
        drain();

        for (int p = 0; p < 6; p++) begin
            write_size(11'(sizes[p]));
            if (p == 2) begin
                send_idle_pct = 63;
                recv_idle_pct = 32;
            end
            if (p == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_off_cycles = 3000;
            end
            random_phase(sizes[p] >= 1024 ? 380 : 130, 55);
            drain();
        end
        write_size(11'd13);
        random_phase(60, 70);
        drain();

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ===== files.f =====
src/dhtp_pkg.sv
src/dhtp_if.sv
src/dhtp_ram.sv
src/dhtp_divider.sv
src/double_hash_table_probe_core.sv
verif/tb_top.sv
